/* design/elqm_pkg.sv */
`default_nettype none

package elqm_pkg;

   // Fixed field widths of the request and response.
   localparam int MODE_W = 2;
   localparam int KEY_W  = 6;
   localparam int TXN_W  = 4;
   localparam int WAIT_W = 8;

   // Default sizing of the block.
   localparam int DEF_NUM_KEYS    = 64;
   localparam int DEF_QUEUE_DEPTH = 8;
   localparam int DEF_NUM_TXNS    = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOCK    = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_QUERY   = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_WUPD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key_index;
      logic [TXN_W-1:0]  txn_id;
   } req_type;

   typedef struct packed {
      logic             granted;
      logic             queue_full;
      logic             ready_valid;
      logic [TXN_W-1:0] ready_txn;
      logic             locked;
      logic [TXN_W-1:0] owner_txn;
   } rsp_type;

   typedef struct packed {
      logic found;
      logic front;
   } qstat_type;

endpackage

`default_nettype wire

/* design/exclusive_lock_queue_manager.sv */
`default_nettype none

// FIFO exclusive lock manager. Each request names a key and a transaction and
// is a lock request, a release or a status query; each gives exactly one
// response. Per key, the queue of waiting transactions and its length live in
// one synchronous memory word; per transaction, an 8-bit wait count lives in a
// second memory. After reset the block sweeps both memories to zero, over
// max(NUM_KEYS, NUM_TXNS) addresses, and accepts no request during the sweep.
// A lock request, a query, or a release that does not hand the lock over goes
// through the accept cycle, whose closing edge also reads both memories, the
// read-modify-write of the queue word, and the loading of the response
// register, which waits while the output register holds a stalled response.
// A release that hands the lock to the next transaction adds a second
// read-modify-write, of that transaction's wait count, before the loading.
// One request is in work at a time; the next is accepted once the
// response has been loaded into the output register, so a stalled response
// costs nothing until the register is needed again.
module exclusive_lock_queue_manager import elqm_pkg::*; #(
   parameter int NUM_KEYS    = DEF_NUM_KEYS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int NUM_TXNS    = DEF_NUM_TXNS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int KW    = $clog2(NUM_KEYS);
   localparam int TW    = $clog2(NUM_TXNS);
   localparam int LW    = $clog2(QUEUE_DEPTH + 1);
   localparam int EW    = QUEUE_DEPTH * TXN_W;
   localparam int CLR_N = (NUM_KEYS > NUM_TXNS) ? NUM_KEYS : NUM_TXNS;
   localparam int CW    = $clog2(CLR_N);

   // Key and transaction fields reduced modulo the configured counts.
   logic [KW-1:0]    key_tab [2**KEY_W];
   logic [TXN_W-1:0] txn_tab [2**TXN_W];

   for (genvar g = 0; g < 2**KEY_W; g++) begin : g_key_tab
      assign key_tab[g] = KW'(g % NUM_KEYS);
   end
   for (genvar g = 0; g < 2**TXN_W; g++) begin : g_txn_tab
      assign txn_tab[g] = TXN_W'(g % NUM_TXNS);
   end

   // Memories.
   logic [LW+EW-1:0]  key_mem  [NUM_KEYS];
   logic [WAIT_W-1:0] wait_mem [NUM_TXNS];

   logic [LW-1:0]     len_rd_ff;
   logic [EW-1:0]     ent_rd_ff;
   logic [WAIT_W-1:0] wait_rd_ff;

   logic              key_we;
   logic [KW-1:0]     key_wa;
   logic [LW-1:0]     len_wd;
   logic [EW-1:0]     ent_wd;
   logic              wait_we;
   logic [TW-1:0]     wait_wa;
   logic [WAIT_W-1:0] wait_wd;
   logic [TW-1:0]     wait_ra;

   // Control and working registers.
   state_type         state_ff, state_in;
   logic [CW-1:0]     clr_ff, clr_in;
   mode_type          mode_ff, mode_in;
   logic [KW-1:0]     key_ff, key_in;
   logic [TXN_W-1:0]  txn_ff, txn_in;
   logic [TXN_W-1:0]  nxt_ff, nxt_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              req_acc;
   logic              rsp_free;
   logic              clr_last;
   logic [EW-1:0]     app_entries;
   logic [EW-1:0]     rel_entries;
   qstat_type         qstat;
   logic              handover;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign clr_last  = (clr_ff == CW'(CLR_N - 1));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   elqm_qword_ops #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_qword_ops (
      .entries    (ent_rd_ff),
      .len        (len_rd_ff),
      .txn        (txn_ff),
      .app_entries(app_entries),
      .rel_entries(rel_entries),
      .stat       (qstat)
   );

   // A release of the owner with others still waiting passes the lock on.
   assign handover = (mode_ff == MODE_RELEASE) && qstat.front && (len_rd_ff > LW'(1));

   // Queue memory: one word per key holding the length and the entries, with
   // one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_wa] <= {len_wd, ent_wd};
      end
      {len_rd_ff, ent_rd_ff} <= key_mem[key_tab[req_data.key_index]];
   end

   // Wait count memory.
   always_ff @(posedge clock) begin
      if (wait_we) begin
         wait_mem[wait_wa] <= wait_wd;
      end
      wait_rd_ff <= wait_mem[wait_ra];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = handover ? ST_WUPD : ST_DONE;
         end
         ST_WUPD: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs of the sequencer: memory writes, working registers and result.
   always_comb begin
      clr_in       = clr_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      txn_in       = txn_ff;
      nxt_in       = nxt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      key_we       = 1'b0;
      key_wa       = key_ff;
      len_wd       = len_rd_ff;
      ent_wd       = ent_rd_ff;
      wait_we      = 1'b0;
      wait_wa      = TW'(txn_ff);
      wait_wd      = wait_rd_ff;
      wait_ra      = TW'(txn_tab[req_data.txn_id]);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + CW'(1);
            // The sweep covers the larger memory; the smaller stops early.
            key_we  = ({1'b0, clr_ff} < (CW+1)'(NUM_KEYS));
            key_wa  = clr_ff[KW-1:0];
            len_wd  = '0;
            ent_wd  = '0;
            wait_we = ({1'b0, clr_ff} < (CW+1)'(NUM_TXNS));
            wait_wa = clr_ff[TW-1:0];
            wait_wd = '0;
         end
         ST_IDLE: begin
            if (req_acc) begin
               mode_in = mode_type'(req_data.mode);
               key_in  = key_tab[req_data.key_index];
               txn_in  = txn_tab[req_data.txn_id];
            end
         end
         ST_LOOK: begin
            res_in = '0;
            nxt_in = rel_entries[TXN_W-1:0];
            wait_ra = TW'(rel_entries[TXN_W-1:0]);
            case (mode_ff)
               MODE_LOCK: begin
                  if (len_rd_ff >= LW'(QUEUE_DEPTH)) begin
                     res_in.queue_full = 1'b1;
                  end else begin
                     key_we = 1'b1;
                     len_wd = len_rd_ff + LW'(1);
                     ent_wd = app_entries;
                     if (len_rd_ff == '0) begin
                        res_in.granted = 1'b1;
                     end else if (wait_rd_ff != '1) begin
                        wait_we = 1'b1;
                        wait_wd = wait_rd_ff + WAIT_W'(1);
                     end
                  end
               end
               MODE_RELEASE: begin
                  if (qstat.found) begin
                     key_we = 1'b1;
                     len_wd = len_rd_ff - LW'(1);
                     ent_wd = rel_entries;
                  end
               end
               MODE_QUERY: begin
                  if (len_rd_ff != '0) begin
                     res_in.locked    = 1'b1;
                     res_in.owner_txn = ent_rd_ff[TXN_W-1:0];
                  end
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end
         ST_WUPD: begin
            // The new owner waits for one holder fewer.
            if (wait_rd_ff != '0) begin
               wait_we = 1'b1;
               wait_wa = TW'(nxt_ff);
               wait_wd = wait_rd_ff - WAIT_W'(1);
               if (wait_rd_ff == WAIT_W'(1)) begin
                  res_in.ready_valid = 1'b1;
                  res_in.ready_txn   = nxt_ff;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      txn_ff      <= txn_in;
      nxt_ff      <= nxt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // A response never both grants and refuses a lock.
   a_grant_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.granted && rsp_data.queue_full))
      else $error("granted and queue_full both set");

   // A ready report comes only from a release, never with lock or query fields.
   a_ready_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.ready_valid) |-> (!rsp_data.granted && !rsp_data.locked))
      else $error("ready report mixed with other fields");

   // No request is taken while the memories are being swept.
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("request accepted during clearing sweep");

   // A stored queue length never exceeds the queue depth.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |-> (len_rd_ff <= LW'(QUEUE_DEPTH)))
      else $error("queue length out of range");
`endif

endmodule

`default_nettype wire

/* design/elqm_qword_ops.sv */
`default_nettype none

// Edits of one key's queue word: append at the tail, and removal of the first
// entry of a transaction with the later entries moved down by one slot.
module elqm_qword_ops import elqm_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   localparam int LW = $clog2(QUEUE_DEPTH + 1),
   localparam int PW = $clog2(QUEUE_DEPTH),
   localparam int EW = QUEUE_DEPTH * TXN_W
) (
   input  wire logic [EW-1:0]    entries,
   input  wire logic [LW-1:0]    len,
   input  wire logic [TXN_W-1:0] txn,
   output logic      [EW-1:0]    app_entries,
   output logic      [EW-1:0]    rel_entries,
   output qstat_type             stat
);

   logic          found;
   logic [PW-1:0] pos;

   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if ((LW'(i) < len) && (entries[i*TXN_W +: TXN_W] == txn)) begin
            found = 1'b1;
            pos   = PW'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         app_entries[i*TXN_W +: TXN_W] = (LW'(i) == len) ? txn : entries[i*TXN_W +: TXN_W];
         if ((i < int'(pos)) || (i + 1 >= QUEUE_DEPTH)) begin
            rel_entries[i*TXN_W +: TXN_W] = entries[i*TXN_W +: TXN_W];
         end else begin
            rel_entries[i*TXN_W +: TXN_W] = entries[(i+1)*TXN_W +: TXN_W];
         end
      end
   end

   assign stat.found = found;
   assign stat.front = found && (pos == '0);

endmodule

`default_nettype wire

/* tb/sv/exclusive_lock_queue_manager_tb.sv */
`timescale 1ns / 100ps

import elqm_pkg::*;

// Scoreboard: a predictor of the lock manager holding its own per-key queues
// and per-transaction wait counts, and a FIFO of predicted responses.
class lock_scoreboard;
   logic [TXN_W-1:0] key_queue [DEF_NUM_KEYS][DEF_QUEUE_DEPTH];
   int               key_len   [DEF_NUM_KEYS];
   logic [7:0]       txn_wait  [DEF_NUM_TXNS];
   rsp_type          pending_rsp [$];
   int               mismatches;

   function new();
      for (int k = 0; k < DEF_NUM_KEYS; k++) begin
         key_len[k] = 0;
         for (int d = 0; d < DEF_QUEUE_DEPTH; d++) key_queue[k][d] = '0;
      end
      for (int t = 0; t < DEF_NUM_TXNS; t++) txn_wait[t] = '0;
      mismatches = 0;
   endfunction

   // Works out the response to one accepted request and updates the state.
   function void note_request(req_type rq);
      rsp_type          r;
      int               k;
      int               len;
      int               pos;
      logic [TXN_W-1:0] nxt;
      r   = '0;
      k   = rq.key_index;
      len = key_len[k];
      case (rq.mode)
         MODE_LOCK: begin
            if (len >= DEF_QUEUE_DEPTH) begin
               r.queue_full = 1'b1;
            end else begin
               key_queue[k][len] = rq.txn_id;
               key_len[k] = len + 1;
               if (len == 0) r.granted = 1'b1;
               else if (txn_wait[rq.txn_id] != 8'd255) txn_wait[rq.txn_id]++;
            end
         end
         MODE_RELEASE: begin
            pos = len;
            for (int i = len - 1; i >= 0; i--)
               if (key_queue[k][i] == rq.txn_id) pos = i;
            if (pos < len) begin
               for (int i = pos; i + 1 < len; i++) key_queue[k][i] = key_queue[k][i+1];
               len--;
               key_len[k] = len;
               if (pos == 0 && len > 0) begin
                  nxt = key_queue[k][0];
                  if (txn_wait[nxt] != 0) begin
                     txn_wait[nxt]--;
                     if (txn_wait[nxt] == 0) begin
                        r.ready_valid = 1'b1;
                        r.ready_txn   = nxt;
                     end
                  end
               end
            end
         end
         MODE_QUERY: begin
            if (len > 0) begin
               r.locked    = 1'b1;
               r.owner_txn = key_queue[k][0];
            end
         end
         default: ;
      endcase
      pending_rsp.insert(pending_rsp.size(), r);
   endfunction

   function void check_response(rsp_type act);
      rsp_type exp;
      if (pending_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("Unexpected response %h", act);
         return;
      end
      exp = pending_rsp.pop_front();
      if (act !== exp) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Response mismatch: expected %h, actual %h", exp, act);
      end
   endfunction
endclass

module exclusive_lock_queue_manager_tb;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   lock_scoreboard sb = new();

   // When set, the response side never stalls; used for stretches with no idling.
   bit no_idle = 1'b0;

   always #10 clock = ~clock;

   exclusive_lock_queue_manager u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Gap length: mostly short, now and then long.
   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // Responses are checked at the edge where they are accepted; the stall is
   // then redrawn for the next cycle with a single nonblocking assignment.
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if (no_idle) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left = gap_length();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Sends one request and holds it until the block accepts it. The request is
   // noted in the scoreboard at the edge of acceptance. Valid stays high after
   // acceptance when the next request follows with no gap; a gap or a drain
   // drops it.
   task automatic send_request(logic [1:0] mode, logic [5:0] key, logic [3:0] txn,
                               bit idle);
      int gap;
      gap = idle ? gap_length() : 0;
      if ($urandom_range(0, 2) != 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{mode: mode, key_index: key, txn_id: txn};
      do @(posedge clock); while (req_stall);
      sb.note_request(req_data);
   endtask

   // Waits until every predicted response has arrived.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [5:0] key;
      logic [3:0] txn;
      int         pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: grant, queueing, full queue, releases of owner, of a
      // waiter and of an absent transaction, queries, and the unused mode.
      send_request(MODE_QUERY, 6'd0, 4'd0, 0);
      for (int i = 0; i < 8; i++) send_request(MODE_LOCK, 6'd63, 4'(i * 2 + 1), 0);
      send_request(MODE_LOCK, 6'd63, 4'd15, 0);
      send_request(MODE_QUERY, 6'd63, 4'd0, 0);
      send_request(MODE_RELEASE, 6'd63, 4'd0, 0);
      send_request(MODE_RELEASE, 6'd63, 4'd5, 0);
      send_request(MODE_RELEASE, 6'd63, 4'd1, 0);
      send_request(MODE_RELEASE, 6'd63, 4'd3, 0);
      send_request(MODE_QUERY, 6'd63, 4'd15, 0);
      send_request(2'd3, 6'd63, 4'd15, 0);
      send_request(MODE_LOCK, 6'd0, 4'd0, 0);
      send_request(MODE_LOCK, 6'd0, 4'd15, 0);
      send_request(MODE_RELEASE, 6'd0, 4'd0, 0);
      send_request(MODE_QUERY, 6'd0, 4'd0, 0);
      // Sender pause until everything has come back.
      drain_responses();

      // Random part: mostly locks and releases on a few hot keys, so queues
      // fill, hand over and saturate wait counts; the rest is broad noise.
      for (int n = 0; n < 1300; n++) begin
         no_idle = (n >= 600 && n < 700);
         pick = $urandom_range(0, 99);
         key  = (pick < 70) ? 6'($urandom_range(0, 3)) : 6'($urandom);
         txn  = (pick < 70) ? 4'($urandom_range(0, 5)) : 4'($urandom);
         if (pick % 10 < 5)      send_request(MODE_LOCK, key, txn, !no_idle);
         else if (pick % 10 < 8) send_request(MODE_RELEASE, key, txn, !no_idle);
         else if (pick % 10 < 9) send_request(MODE_QUERY, key, txn, !no_idle);
         else                    send_request(2'($urandom), key, txn, !no_idle);
         if (n == 900) drain_responses();
      end

      drain_responses();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
